/* hdl/tvsz_pkg.sv */
`default_nettype none

package tvsz_pkg;

   // zoom levels in use, and index width for the level table
   localparam int ZOOM_STEPS = 5;
   localparam int ZIDX_W     = 3;

   // scroll offsets
   localparam int OFF_W = 18;
   localparam logic [OFF_W-1:0] OFFSET_MAX = 18'h3FFFF;

   // shared divider: 28-bit dividend, 4 quotient bits per cycle
   localparam int DIV_W     = 28;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = DIV_W / DIV_BITS;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam int REM_W     = 9;

   // operation codes of an input beat
   typedef enum logic [2:0] {
      OP_MOVE     = 3'd0,
      OP_ZOOM_IN  = 3'd1,
      OP_ZOOM_OUT = 3'd2,
      OP_SCR2CELL = 3'd3,
      OP_CELL2SCR = 3'd4
   } op_type;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_VIEW_W = 3'd0,
      CSR_VIEW_H = 3'd1,
      CSR_MAP_C  = 3'd2,
      CSR_MAP_R  = 3'd3,
      CSR_TILE   = 3'd4
   } csr_type;

   // datapath micro operations, one per cycle
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MOVE,
      DP_ZSEL,
      DP_MUL_CEN,
      DP_MUL_VIEW,
      DP_DIV_REC,
      DP_DIV_SCR,
      DP_DIV_STEP,
      DP_PUT_OFF,
      DP_PUT_CELL,
      DP_MUL_CELL,
      DP_PUT_SCR,
      DP_COMMIT,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      axis_y;     // 0 works on x, 1 on y
      logic      zoom_up;    // direction for the level select
      logic      lim_mul;    // limit pipe: map * tile
      logic      lim_sub;    // limit pipe: subtract view, saturate
      logic      lim_clamp;  // limit pipe: clamp offsets
   } dp_cmd_type;

   typedef struct packed {
      logic cfg_hit;   // valid register written this cycle
      logic up_ok;     // a larger level exists
      logic down_ok;   // a smaller level exists
   } dp_sts_type;

   function automatic logic [7:0] zoom_level(input logic [ZIDX_W-1:0] idx);
      logic [7:0] lv;
      case (idx)
         3'd0:    lv = 8'd12;
         3'd1:    lv = 8'd16;
         3'd2:    lv = 8'd24;
         3'd3:    lv = 8'd32;
         3'd4:    lv = 8'd48;
         3'd5:    lv = 8'd64;
         3'd6:    lv = 8'd96;
         default: lv = 8'd128;
      endcase
      return lv;
   endfunction

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // nearest level, ties to the lower index
   function automatic logic [ZIDX_W-1:0] nearest_level(input logic [7:0] tile);
      logic [ZIDX_W-1:0] best;
      logic [7:0]        best_d;
      logic [7:0]        d;
      best   = '0;
      best_d = abs_diff(zoom_level('0), tile);
      for (int i = 1; i < ZOOM_STEPS; i++) begin
         d = abs_diff(zoom_level(ZIDX_W'(i)), tile);
         if (d < best_d) begin
            best_d = d;
            best   = ZIDX_W'(i);
         end
      end
      return best;
   endfunction

endpackage

`default_nettype wire

/* hdl/tvsz_dp.sv */
`default_nettype none

module tvsz_dp import tvsz_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_sts_type              sts,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [11:0]        csr_wdata,
   input  wire logic signed [15:0] req_move_dx,
   input  wire logic signed [15:0] req_move_dy,
   input  wire logic [11:0]        req_screen_x,
   input  wire logic [11:0]        req_screen_y,
   input  wire logic [9:0]         req_cell_column,
   input  wire logic [9:0]         req_cell_row,
   output logic signed [19:0]      rsp_result_x,
   output logic signed [19:0]      rsp_result_y,
   output logic [17:0]             rsp_scroll_x,
   output logic [17:0]             rsp_scroll_y,
   output logic [7:0]              rsp_tile_pixels
);

   // configuration and view state
   logic [11:0]      vw_ff, vw_in, vh_ff, vh_in;
   logic [10:0]      mc_ff, mc_in, mr_ff, mr_in;
   logic [7:0]       its_ff, its_in, tile_ff, tile_in;
   logic [OFF_W-1:0] offx_ff, offx_in, offy_ff, offy_in;

   // limit pipe
   logic [18:0]      lpx_ff, lpx_in, lpy_ff, lpy_in;
   logic [11:0]      lvx_ff, lvx_in, lvy_ff, lvy_in;
   logic [OFF_W-1:0] limx_ff, limx_in, limy_ff, limy_in;

   // shared multiplier and divider
   logic [7:0]       newt_ff, newt_in;
   logic [27:0]      prod_ff, prod_in, hold_ff, hold_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;

   // latched request and results
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [11:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic [9:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic signed [19:0] resx_ff, resx_in, resy_ff, resy_in;
   logic signed [19:0] orx_ff, orx_in, ory_ff, ory_in;
   logic [OFF_W-1:0]   osx_ff, osx_in, osy_ff, osy_in;
   logic [7:0]         otile_ff, otile_in;

   logic [ZIDX_W-1:0]  zidx;
   logic               cfg_hit;
   logic [OFF_W-1:0]   off_a;
   logic [11:0]        view_a;
   logic [9:0]         cell_a;
   logic [11:0]        scr_a;
   logic [19:0]        mul_a;
   logic [7:0]         mul_b;
   logic [27:0]        mul_p;
   logic [28:0]        rec_diff;
   logic [DIV_W-1:0]   rec_dvd, scr_dvd;
   logic [DIV_W-1:0]   dq;
   logic [REM_W-1:0]   dr;
   logic [REM_W:0]     dt;
   logic [OFF_W-1:0]   q_sat;
   logic [20:0]        scr_diff;
   logic [19:0]        ldx, ldy;
   logic signed [19:0] movx, movy;

   function automatic logic [OFF_W-1:0] clamp_move(input logic signed [19:0] s,
                                                   input logic [OFF_W-1:0] lim);
      logic [OFF_W-1:0] r;
      if (s < 0)
         r = '0;
      else if (s[18:0] > {1'b0, lim})
         r = lim;
      else
         r = s[OFF_W-1:0];
      return r;
   endfunction

   function automatic logic [OFF_W-1:0] sat_limit(input logic [19:0] d);
      logic [OFF_W-1:0] r;
      if (d[19])
         r = '0;
      else if (d[18])
         r = OFFSET_MAX;
      else
         r = d[OFF_W-1:0];
      return r;
   endfunction

   // status
   assign zidx    = nearest_level(tile_ff);
   assign cfg_hit = csr_we && (csr_index inside {[CSR_VIEW_W:CSR_TILE]});
   assign sts.cfg_hit = cfg_hit;
   assign sts.up_ok   = zidx < ZIDX_W'(ZOOM_STEPS - 1);
   assign sts.down_ok = zidx != '0;

   // axis selection
   assign off_a  = cmd.axis_y ? offy_ff : offx_ff;
   assign view_a = cmd.axis_y ? vh_ff : vw_ff;
   assign cell_a = cmd.axis_y ? cy_ff : cx_ff;
   assign scr_a  = cmd.axis_y ? sy_ff : sx_ff;

   // multiplier operands
   always_comb begin
      case (cmd.op)
         DP_MUL_CEN: begin
            mul_a = 20'({off_a, 1'b0}) + 20'(view_a);
            mul_b = newt_ff;
         end
         DP_MUL_VIEW: begin
            mul_a = 20'(view_a);
            mul_b = tile_ff;
         end
         DP_MUL_CELL: begin
            mul_a = 20'(cell_a);
            mul_b = tile_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 28'(mul_a) * 28'(mul_b);

   // dividends: a negative recentred numerator divides as zero
   assign rec_diff = {1'b0, hold_ff} - {1'b0, prod_ff};
   assign rec_dvd  = rec_diff[28] ? '0 : rec_diff[DIV_W-1:0];
   assign scr_dvd  = DIV_W'(scr_a) + DIV_W'(off_a);

   // radix-16 restoring step
   always_comb begin
      dr = rem_ff;
      dq = quo_ff;
      dt = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         dt = {dr, dq[DIV_W-1]};
         if (dt >= {1'b0, dvsr_ff}) begin
            dt = dt - {1'b0, dvsr_ff};
            dq = {dq[DIV_W-2:0], 1'b1};
         end else begin
            dq = {dq[DIV_W-2:0], 1'b0};
         end
         dr = dt[REM_W-1:0];
      end
   end

   assign q_sat    = (|quo_ff[DIV_W-1:OFF_W]) ? OFFSET_MAX : quo_ff[OFF_W-1:0];
   assign scr_diff = {3'b000, prod_ff[OFF_W-1:0]} - {3'b000, off_a};
   assign ldx      = {1'b0, lpx_ff} - {8'd0, lvx_ff};
   assign ldy      = {1'b0, lpy_ff} - {8'd0, lvy_ff};
   assign movx     = signed'({2'b00, offx_ff}) + 20'(dx_ff);
   assign movy     = signed'({2'b00, offy_ff}) + 20'(dy_ff);

   // next state
   always_comb begin
      vw_in = vw_ff;   vh_in = vh_ff;   mc_in = mc_ff;   mr_in = mr_ff;
      its_in = its_ff; tile_in = tile_ff;
      offx_in = offx_ff; offy_in = offy_ff;
      lpx_in = lpx_ff; lpy_in = lpy_ff; lvx_in = lvx_ff; lvy_in = lvy_ff;
      limx_in = limx_ff; limy_in = limy_ff;
      newt_in = newt_ff; prod_in = prod_ff; hold_in = hold_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvsr_in = dvsr_ff;
      dx_in = dx_ff; dy_in = dy_ff; sx_in = sx_ff; sy_in = sy_ff;
      cx_in = cx_ff; cy_in = cy_ff; resx_in = resx_ff; resy_in = resy_ff;
      orx_in = orx_ff; ory_in = ory_ff; osx_in = osx_ff; osy_in = osy_ff;
      otile_in = otile_ff;

      // valid register writes reload the tile size
      if (cfg_hit) begin
         case (csr_index)
            CSR_VIEW_W: vw_in  = csr_wdata;
            CSR_VIEW_H: vh_in  = csr_wdata;
            CSR_MAP_C:  mc_in  = csr_wdata[10:0];
            CSR_MAP_R:  mr_in  = csr_wdata[10:0];
            CSR_TILE:   its_in = csr_wdata[7:0];
            default:    its_in = its_ff;
         endcase
         tile_in = (its_in == '0) ? 8'd1 : its_in;
      end

      // limit pipe
      if (cmd.lim_mul) begin
         lpx_in = 19'(mc_ff) * 19'(tile_ff);
         lpy_in = 19'(mr_ff) * 19'(tile_ff);
         lvx_in = vw_ff;
         lvy_in = vh_ff;
      end
      if (cmd.lim_sub) begin
         limx_in = sat_limit(ldx);
         limy_in = sat_limit(ldy);
      end
      if (cmd.lim_clamp) begin
         offx_in = (offx_ff > limx_ff) ? limx_ff : offx_ff;
         offy_in = (offy_ff > limy_ff) ? limy_ff : offy_ff;
      end

      case (cmd.op)
         DP_LOAD: begin
            dx_in = req_move_dx;     dy_in = req_move_dy;
            sx_in = req_screen_x;    sy_in = req_screen_y;
            cx_in = req_cell_column; cy_in = req_cell_row;
            resx_in = '0;            resy_in = '0;
         end
         DP_MOVE: begin
            offx_in = clamp_move(movx, limx_ff);
            offy_in = clamp_move(movy, limy_ff);
         end
         DP_ZSEL: begin
            newt_in = zoom_level(cmd.zoom_up ? ZIDX_W'(zidx + 1'b1)
                                             : ZIDX_W'(zidx - 1'b1));
         end
         DP_MUL_CEN, DP_MUL_CELL: begin
            prod_in = mul_p;
         end
         DP_MUL_VIEW: begin
            hold_in = prod_ff;
            prod_in = mul_p;
         end
         DP_DIV_REC: begin
            quo_in  = rec_dvd;
            rem_in  = '0;
            dvsr_in = {tile_ff, 1'b0};
         end
         DP_DIV_SCR: begin
            quo_in  = scr_dvd;
            rem_in  = '0;
            dvsr_in = {1'b0, tile_ff};
         end
         DP_DIV_STEP: begin
            quo_in = dq;
            rem_in = dr;
         end
         DP_PUT_OFF: begin
            if (cmd.axis_y)
               offy_in = q_sat;
            else
               offx_in = q_sat;
         end
         DP_PUT_CELL: begin
            if (cmd.axis_y)
               resy_in = signed'(quo_ff[19:0]);
            else
               resx_in = signed'(quo_ff[19:0]);
         end
         DP_PUT_SCR: begin
            if (cmd.axis_y)
               resy_in = signed'(scr_diff[19:0]);
            else
               resx_in = signed'(scr_diff[19:0]);
         end
         DP_COMMIT: begin
            tile_in = newt_ff;
         end
         DP_OUT: begin
            orx_in   = resx_ff;
            ory_in   = resy_ff;
            osx_in   = offx_ff;
            osy_in   = offy_ff;
            otile_in = tile_ff;
         end
         default: begin
            newt_in = newt_ff;
         end
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff   <= 12'd640;
         vh_ff   <= 12'd480;
         mc_ff   <= 11'd100;
         mr_ff   <= 11'd100;
         its_ff  <= 8'd32;
         tile_ff <= 8'd32;
         offx_ff <= '0;
         offy_ff <= '0;
      end else begin
         vw_ff   <= vw_in;
         vh_ff   <= vh_in;
         mc_ff   <= mc_in;
         mr_ff   <= mr_in;
         its_ff  <= its_in;
         tile_ff <= tile_in;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lpx_ff   <= lpx_in;   lpy_ff  <= lpy_in;
      lvx_ff   <= lvx_in;   lvy_ff  <= lvy_in;
      limx_ff  <= limx_in;  limy_ff <= limy_in;
      newt_ff  <= newt_in;  prod_ff <= prod_in;  hold_ff <= hold_in;
      quo_ff   <= quo_in;   rem_ff  <= rem_in;   dvsr_ff <= dvsr_in;
      dx_ff    <= dx_in;    dy_ff   <= dy_in;
      sx_ff    <= sx_in;    sy_ff   <= sy_in;
      cx_ff    <= cx_in;    cy_ff   <= cy_in;
      resx_ff  <= resx_in;  resy_ff <= resy_in;
      orx_ff   <= orx_in;   ory_ff  <= ory_in;
      osx_ff   <= osx_in;   osy_ff  <= osy_in;
      otile_ff <= otile_in;
   end

   assign rsp_result_x    = orx_ff;
   assign rsp_result_y    = ory_ff;
   assign rsp_scroll_x    = osx_ff;
   assign rsp_scroll_y    = osy_ff;
   assign rsp_tile_pixels = otile_ff;

endmodule

`default_nettype wire

/* hdl/tvsz_ctrl.sv */
`default_nettype none

module tvsz_ctrl import tvsz_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_operation,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   typedef enum logic [14:0] {
      S_IDLE    = 15'b000000000000001,
      S_MOVE    = 15'b000000000000010,
      S_ZSEL    = 15'b000000000000100,
      S_ZMUL1   = 15'b000000000001000,
      S_ZMUL2   = 15'b000000000010000,
      S_ZDIV0   = 15'b000000000100000,
      S_DIVRUN  = 15'b000000001000000,
      S_ZPUT    = 15'b000000010000000,
      S_ZCOMMIT = 15'b000000100000000,
      S_ZWAIT   = 15'b000001000000000,
      S_SDIV0   = 15'b000010000000000,
      S_SPUT    = 15'b000100000000000,
      S_CMUL    = 15'b001000000000000,
      S_CPUT    = 15'b010000000000000,
      S_FINISH  = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]        op_ff, op_in;
   logic              axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        pend_ff, pend_in;
   logic              commit;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE) && (pend_ff == '0) && !sts.cfg_hit;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // limit pipe runs after reset, every valid register write and tile change
   assign pend_in = {pend_ff[1:0], sts.cfg_hit | commit};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      commit       = 1'b0;

      cmd.op        = DP_NOP;
      cmd.axis_y    = axis_ff;
      cmd.zoom_up   = (op_ff == OP_ZOOM_IN);
      cmd.lim_mul   = pend_ff[0];
      cmd.lim_sub   = pend_ff[1];
      cmd.lim_clamp = pend_ff[2];

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op  = DP_LOAD;
               op_in   = req_operation;
               axis_in = 1'b0;
               case (req_operation)
                  OP_MOVE:                state_in = S_MOVE;
                  OP_ZOOM_IN, OP_ZOOM_OUT: state_in = S_ZSEL;
                  OP_SCR2CELL:            state_in = S_SDIV0;
                  OP_CELL2SCR:            state_in = S_CMUL;
                  default:                state_in = S_FINISH;
               endcase
            end
         end
         S_MOVE: begin
            cmd.op   = DP_MOVE;
            state_in = S_FINISH;
         end
         S_ZSEL: begin
            if (cmd.zoom_up ? sts.up_ok : sts.down_ok) begin
               cmd.op   = DP_ZSEL;
               state_in = S_ZMUL1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ZMUL1: begin
            cmd.op   = DP_MUL_CEN;
            state_in = S_ZMUL2;
         end
         S_ZMUL2: begin
            cmd.op   = DP_MUL_VIEW;
            state_in = S_ZDIV0;
         end
         S_ZDIV0: begin
            cmd.op   = DP_DIV_REC;
            cnt_in   = '0;
            state_in = S_DIVRUN;
         end
         S_SDIV0: begin
            cmd.op   = DP_DIV_SCR;
            cnt_in   = '0;
            state_in = S_DIVRUN;
         end
         S_DIVRUN: begin
            cmd.op = DP_DIV_STEP;
            cnt_in = DCNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1))
               state_in = (op_ff == OP_SCR2CELL) ? S_SPUT : S_ZPUT;
         end
         S_ZPUT: begin
            cmd.op = DP_PUT_OFF;
            if (axis_ff) begin
               state_in = S_ZCOMMIT;
            end else begin
               axis_in  = 1'b1;
               state_in = S_ZMUL1;
            end
         end
         S_ZCOMMIT: begin
            cmd.op   = DP_COMMIT;
            commit   = 1'b1;
            state_in = S_ZWAIT;
         end
         S_ZWAIT: begin
            // leave on the clamp beat of the limit pipe
            if (pend_ff == 3'b100)
               state_in = S_FINISH;
         end
         S_SPUT: begin
            cmd.op = DP_PUT_CELL;
            if (axis_ff) begin
               state_in = S_FINISH;
            end else begin
               axis_in  = 1'b1;
               state_in = S_SDIV0;
            end
         end
         S_CMUL: begin
            cmd.op   = DP_MUL_CELL;
            state_in = S_CPUT;
         end
         S_CPUT: begin
            cmd.op = DP_PUT_SCR;
            if (axis_ff) begin
               state_in = S_FINISH;
            end else begin
               axis_in  = 1'b1;
               state_in = S_CMUL;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         op_ff        <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 3'b001;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/tile_viewport_scroll_zoom.sv */
// Viewport unit for a tile map: holds the x/y scroll offset and the tile size, and answers
// one item at a time with one result beat carrying the conversion result and the state after
// the item. Screen-to-cell and zoom items are paced by the shared divider, which retires
// 4 quotient bits per cycle over a 28-bit dividend (two divisions per screen-to-cell item
// or zoom); a zoom is also followed by the 3-stage limit pipe (map size times tile, minus
// viewport, clamp). A zoom with no neighbouring level skips the divisions and the limit
// pipe. The block is back in idle before the next accept. The same limit pipe runs after
// reset and after each valid register write; req_ready stays low until it drains. A result
// waiting on rsp_ready does not keep the next item from being accepted.

`default_nettype none

module tile_viewport_scroll_zoom import tvsz_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [15:0] req_move_dx,
   input  wire logic signed [15:0] req_move_dy,
   input  wire logic [11:0]        req_screen_x,
   input  wire logic [11:0]        req_screen_y,
   input  wire logic [9:0]         req_cell_column,
   input  wire logic [9:0]         req_cell_row,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [19:0]      rsp_result_x,
   output logic signed [19:0]      rsp_result_y,
   output logic [17:0]             rsp_scroll_x,
   output logic [17:0]             rsp_scroll_y,
   output logic [7:0]              rsp_tile_pixels,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [11:0]        csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   tvsz_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   tvsz_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_move_dx     (req_move_dx),
      .req_move_dy     (req_move_dy),
      .req_screen_x    (req_screen_x),
      .req_screen_y    (req_screen_y),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .rsp_result_x    (rsp_result_x),
      .rsp_result_y    (rsp_result_y),
      .rsp_scroll_x    (rsp_scroll_x),
      .rsp_scroll_y    (rsp_scroll_y),
      .rsp_tile_pixels (rsp_tile_pixels)
   );

   // no item is taken while the limit pipe still has to clamp
   a_ready_no_clamp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !cmd.lim_clamp)
      else $error("item accepted with limit clamp pending");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while busy");

   // a result beat only appears after the output registers were loaded
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.op == DP_OUT))
      else $error("result valid without output load");

   // tile size never reaches zero
   a_tile_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tile_pixels != 8'd0))
      else $error("zero tile size on result");

endmodule

`default_nettype wire

/* dv/tile_viewport_scroll_zoom_tb.sv */
`timescale 1ns / 1ps

module tile_viewport_scroll_zoom_tb;
   import tvsz_pkg::*;

   // operation and register codes that the package enums leave out
   localparam logic [2:0] OP_SPARE5  = 3'd5;
   localparam logic [2:0] OP_SPARE6  = 3'd6;
   localparam logic [2:0] OP_SPARE7  = 3'd7;
   localparam logic [2:0] CSR_SPARE5 = 3'd5;
   localparam logic [2:0] CSR_SPARE6 = 3'd6;
   localparam logic [2:0] CSR_SPARE7 = 3'd7;

   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [11:0]        sx;
      logic [11:0]        sy;
      logic [9:0]         col;
      logic [9:0]         row;
   } view_cmd_t;

   typedef struct packed {
      logic [19:0] rx;
      logic [19:0] ry;
      logic [17:0] scx;
      logic [17:0] scy;
      logic [7:0]  tpx;
   } view_state_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic [2:0]         req_operation = '0;
   logic signed [15:0] req_move_dx = '0;
   logic signed [15:0] req_move_dy = '0;
   logic [11:0]        req_screen_x = '0;
   logic [11:0]        req_screen_y = '0;
   logic [9:0]         req_cell_column = '0;
   logic [9:0]         req_cell_row = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire signed [19:0]  rsp_result_x;
   wire signed [19:0]  rsp_result_y;
   wire [17:0]         rsp_scroll_x;
   wire [17:0]         rsp_scroll_y;
   wire [7:0]          rsp_tile_pixels;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [11:0]        csr_wdata = '0;

   always #10 clock = ~clock;

   tile_viewport_scroll_zoom dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_move_dx     (req_move_dx),
      .req_move_dy     (req_move_dy),
      .req_screen_x    (req_screen_x),
      .req_screen_y    (req_screen_y),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_x    (rsp_result_x),
      .rsp_result_y    (rsp_result_y),
      .rsp_scroll_x    (rsp_scroll_x),
      .rsp_scroll_y    (rsp_scroll_y),
      .rsp_tile_pixels (rsp_tile_pixels),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // viewport registers and state as the block should hold them
   longint view_w = 640;
   longint view_h = 480;
   longint map_c = 100;
   longint map_r = 100;
   longint tile_init = 32;
   longint offs_x = 0;
   longint offs_y = 0;
   longint tile_px = 32;

   view_cmd_t   pending_cmds[$];
   view_state_t expected_views[$];
   int          in_flight = 0;
   int          n_errors = 0;
   int          n_cmds = 0;
   int          n_rsp = 0;
   int          n_csr = 0;
   int          n_settings = 0;
   int          op_seen[8];

   bit          send_steady = 0;
   bit          recv_steady = 0;
   bit          hold_arm = 0;
   int          hold_left = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   view_cmd_t   cur_cmd;

   //--------------------------------------------------------------------
   // viewport predictor
   //--------------------------------------------------------------------
   function automatic int level_px(input int i);
      case (i)
         0:       return 12;
         1:       return 16;
         2:       return 24;
         3:       return 32;
         4:       return 48;
         5:       return 64;
         6:       return 96;
         default: return 128;
      endcase
   endfunction

   function automatic int level_count();
      int n;
      n = ZOOM_STEPS;
      if (n < 2) n = 2;
      if (n > 8) n = 8;
      return n;
   endfunction

   // highest legal offset for one axis, saturated at the offset width
   function automatic longint scroll_limit(input longint tiles, input longint view);
      longint m;
      m = tiles * tile_px - view;
      if (m < 0) m = 0;
      if (m > longint'(OFFSET_MAX)) m = longint'(OFFSET_MAX);
      return m;
   endfunction

   function automatic longint clamp_offs(input longint v, input longint hi);
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v;
   endfunction

   function automatic void reclamp();
      offs_x = clamp_offs(offs_x, scroll_limit(map_c, view_w));
      offs_y = clamp_offs(offs_y, scroll_limit(map_r, view_h));
   endfunction

   // ties go to the lower level
   function automatic int nearest_zoom_idx();
      int     best;
      longint best_d;
      longint d;
      best   = 0;
      best_d = level_px(0) - tile_px;
      if (best_d < 0) best_d = -best_d;
      for (int i = 1; i < level_count(); i++) begin
         d = level_px(i) - tile_px;
         if (d < 0) d = -d;
         if (d < best_d) begin
            best_d = d;
            best   = i;
         end
      end
      return best;
   endfunction

   // keep the view center when the tile size changes
   function automatic longint recenter(input longint off, input longint view,
                                       input longint oldt, input longint newt);
      longint num;
      num = (2 * off + view) * newt - view * oldt;
      if (num < 0) return 0;
      return num / (2 * oldt);
   endfunction

   function automatic void set_tile(input longint newt);
      offs_x  = recenter(offs_x, view_w, tile_px, newt);
      offs_y  = recenter(offs_y, view_h, tile_px, newt);
      tile_px = newt;
      reclamp();
   endfunction

   function automatic view_state_t predict_cmd(input view_cmd_t c);
      view_state_t r;
      longint      rx;
      longint      ry;
      int          idx;
      rx = 0;
      ry = 0;
      case (c.op)
         OP_MOVE: begin
            offs_x += longint'(c.dx);
            offs_y += longint'(c.dy);
            reclamp();
         end
         OP_ZOOM_IN: begin
            idx = nearest_zoom_idx();
            if (idx < level_count() - 1) set_tile(level_px(idx + 1));
         end
         OP_ZOOM_OUT: begin
            idx = nearest_zoom_idx();
            if (idx > 0) set_tile(level_px(idx - 1));
         end
         OP_SCR2CELL: begin
            rx = (longint'(c.sx) + offs_x) / tile_px;
            ry = (longint'(c.sy) + offs_y) / tile_px;
         end
         OP_CELL2SCR: begin
            rx = longint'(c.col) * tile_px - offs_x;
            ry = longint'(c.row) * tile_px - offs_y;
         end
         default: ;
      endcase
      r.rx  = rx[19:0];
      r.ry  = ry[19:0];
      r.scx = offs_x[17:0];
      r.scy = offs_y[17:0];
      r.tpx = tile_px[7:0];
      return r;
   endfunction

   // any valid register write reloads the tile size and reclamps
   function automatic void predict_csr(input logic [2:0] idx, input logic [11:0] d);
      case (idx)
         CSR_VIEW_W: view_w = d;
         CSR_VIEW_H: view_h = d;
         CSR_MAP_C:  map_c = d[10:0];
         CSR_MAP_R:  map_r = d[10:0];
         CSR_TILE:   tile_init = d[7:0];
         default:    return;
      endcase
      tile_px = (tile_init < 1) ? 1 : tile_init;
      reclamp();
   endfunction

   //--------------------------------------------------------------------
   // stimulus helpers
   //--------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic view_cmd_t mk_cmd(input logic [2:0] op, input int dx, input int dy,
                                        input int sx, input int sy, input int col,
                                        input int row);
      view_cmd_t c;
      c.op  = op;
      c.dx  = 16'(dx);
      c.dy  = 16'(dy);
      c.sx  = 12'(sx);
      c.sy  = 12'(sy);
      c.col = 10'(col);
      c.row = 10'(row);
      return c;
   endfunction

   function automatic int rand_delta();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return int'($urandom_range(0, 600)) - 300;
      if (r < 9) return int'($urandom_range(0, 10000)) - 5000;
      return int'(16'($urandom));
   endfunction

   function automatic view_cmd_t rand_cmd();
      view_cmd_t c;
      int        r;
      logic [2:0] op;
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_MOVE;
      else if (r < 42) op = OP_ZOOM_IN;
      else if (r < 54) op = OP_ZOOM_OUT;
      else if (r < 74) op = OP_SCR2CELL;
      else if (r < 94) op = OP_CELL2SCR;
      else             op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      c = mk_cmd(op, rand_delta(), rand_delta(), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 1023));
      return c;
   endfunction

   task automatic report_fail(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [19:0] got,
                              input logic [19:0] want);
      if (got !== want)
         report_fail($sformatf("beat %0d: %s is %0h, expected %0h", n_rsp, name, got, want));
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [11:0] d);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      predict_csr(idx, d);
      n_csr++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every queued item accepted and every result back, then let the block settle
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register setting followed by a burst of random items
   task automatic run_phase(input int vw, input int vh, input int mc, input int mr,
                            input int ti, input int n, input bit steady,
                            input bit long_hold);
      int start;
      int vals[5];
      vals  = '{vw, vh, mc, mr, ti};
      start = $urandom_range(0, 4);
      for (int k = 0; k < 5; k++)
         write_csr(3'((start + k) % 5), 12'(vals[(start + k) % 5]));
      n_settings++;
      send_steady = steady;
      recv_steady = steady && !long_hold;
      for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd());
      if (long_hold) begin
         hold_arm = 1;
         wait (hold_left != 0);
         hold_arm = 0;
      end
      wait_idle();
   endtask

   //--------------------------------------------------------------------
   // driver: presents queued beats, random gaps between them
   //--------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_views.push_back(predict_cmd(cur_cmd));
            op_seen[cur_cmd.op]++;
            n_cmds++;
            send_gap = send_steady ? 0 : pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && pending_cmds.size() != 0) begin
               cur_cmd = pending_cmds.pop_front();
               in_flight++;
               req_valid       <= 1'b1;
               req_operation   <= cur_cmd.op;
               req_move_dx     <= cur_cmd.dx;
               req_move_dy     <= cur_cmd.dy;
               req_screen_x    <= cur_cmd.sx;
               req_screen_y    <= cur_cmd.sy;
               req_cell_column <= cur_cmd.col;
               req_cell_row    <= cur_cmd.row;
            end else begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_left <= LONG_HOLD;
      end
   end

   //--------------------------------------------------------------------
   // monitor: checks each result beat against the oldest prediction
   //--------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               report_fail($sformatf("result beat with nothing expected, scroll %0d,%0d",
                                     rsp_scroll_x, rsp_scroll_y));
            end else begin
               view_state_t want;
               want = expected_views.pop_front();
               in_flight--;
               check_field("result_x", rsp_result_x, want.rx);
               check_field("result_y", rsp_result_y, want.ry);
               check_field("scroll_x", 20'(rsp_scroll_x), 20'(want.scx));
               check_field("scroll_y", 20'(rsp_scroll_y), 20'(want.scy));
               check_field("tile_pixels", 20'(rsp_tile_pixels), 20'(want.tpx));
               n_rsp++;
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (recv_steady) begin
            rsp_ready <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   //--------------------------------------------------------------------
   // test sequence
   //--------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset setting 640x480 view, 100x100 map, 32 px tiles
      pending_cmds.push_back(mk_cmd(OP_MOVE, 32767, 32767, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_SCR2CELL, 0, 0, 4095, 4095, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_CELL2SCR, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_CELL2SCR, 0, 0, 0, 0, 1023, 1023));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_IN, 0, 0, 0, 0, 0, 0));
      // already at the top level: nothing changes
      pending_cmds.push_back(mk_cmd(OP_ZOOM_IN, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_IN, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_MOVE, -32768, -32768, 0, 0, 0, 0));
      // offset zero, zoom out: recentred offset goes negative and clamps
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_OUT, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_SCR2CELL, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_MOVE, 1000, 700, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_CELL2SCR, 0, 0, 0, 0, 5, 7));
      pending_cmds.push_back(mk_cmd(OP_SCR2CELL, 0, 0, 100, 4095, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_SPARE5, 1, 1, 4095, 4095, 1023, 1023));
      pending_cmds.push_back(mk_cmd(OP_SPARE6, -1, -1, 1, 1, 1, 1));
      pending_cmds.push_back(mk_cmd(OP_SPARE7, 32767, -32768, 2048, 2048, 512, 512));
      pending_cmds.push_back(mk_cmd(OP_MOVE, -1, 1, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_ZOOM_IN, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_SCR2CELL, 0, 0, 639, 479, 0, 0));
      pending_cmds.push_back(mk_cmd(OP_CELL2SCR, 0, 0, 0, 0, 1023, 0));
      n_settings++;
      wait_idle();

      // extremes: huge view on a one-row map, zero tile size loads 1
      run_phase(4095, 1, 2047, 1, 0, 60, 0, 0);
      // tiny view, 255 px tiles: x limit saturates at the offset width;
      // sender keeps offering while the receiver holds off
      run_phase(1, 1, 2047, 1024, 255, 200, 1, 1);
      // zero viewport and map, tile size halfway between two levels
      run_phase(0, 0, 0, 0, 14, 60, 0, 0);
      run_phase(640, 480, 100, 100, 32, 200, 0, 0);
      run_phase(320, 200, 1024, 1024, 20, 150, 1, 0);

      // writes to unused indexes must leave everything alone
      write_csr(CSR_SPARE5, 12'hFFF);
      write_csr(CSR_SPARE6, 12'h000);
      write_csr(CSR_SPARE7, 12'($urandom));
      pending_cmds.push_back(mk_cmd(OP_SCR2CELL, 0, 0, 4095, 4095, 0, 0));
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         int ti;
         ti = ($urandom_range(0, 1) != 0) ? level_px($urandom_range(0, level_count() - 1))
                                          : $urandom_range(0, 255);
         run_phase($urandom_range(16, 1024), $urandom_range(16, 1024),
                   $urandom_range(1, 300), $urandom_range(1, 300), ti, 120,
                   p[0], 0);
      end

      if (in_flight != 0 || expected_views.size() != 0)
         report_fail($sformatf("%0d results never arrived", expected_views.size()));
      $display("Ran %0d items (%0d results) over %0d register settings, %0d register writes",
               n_cmds, n_rsp, n_settings, n_csr);
      $display("Mix: move %0d, zoom in %0d, zoom out %0d, to cell %0d, to screen %0d, unused %0d",
               op_seen[OP_MOVE], op_seen[OP_ZOOM_IN], op_seen[OP_ZOOM_OUT],
               op_seen[OP_SCR2CELL], op_seen[OP_CELL2SCR],
               op_seen[OP_SPARE5] + op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("Timeout: %0d items accepted, %0d results pending", n_cmds, in_flight);
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/tvsz_pkg.sv
hdl/tvsz_dp.sv
hdl/tvsz_ctrl.sv
hdl/tile_viewport_scroll_zoom.sv
dv/tile_viewport_scroll_zoom_tb.sv
